// File: src/hn_pkg.sv
// ----------------------------------------------------------------------------
// hn_pkg
// Widths, register indexes and stage types shared by the normal kernel.
// ----------------------------------------------------------------------------
`default_nettype none
package hn_pkg;
   localparam int INDEX_BITS_DEFAULT = 12;
   localparam int FIELD_INDEX_W = 12;
   localparam int HEIGHT_W = 24;
   localparam int ADDR_W = 24;
   localparam int NORM_W = 16;
   localparam int NORMZ_W = 15;
   localparam int SPACING_W = 16;
   localparam int PITCH_W = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int DIFF_W = 26;
   localparam int MAG_W = 25;
   localparam int C_W = 19;
   localparam int SQ_W = 50;
   localparam int LEN_W = 52;
   localparam int RES_W = 91;
   localparam int PROD_W = 72;
   localparam int Q_W = 16;
   localparam int STEPS = 16;
   localparam int NUM_LANES = 3;
   localparam logic [Q_W-1:0] NORMAL_MAX = 16'd32767;
   localparam logic [CSR_DATA_W-1:0] SPACING_RESET = 16'd256;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd257;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRID_SPACING = 1'b0,
      REG_ROW_PITCH    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [RES_W-1:0]  residual;
      logic [PROD_W-1:0] partial;
      logic [Q_W-1:0]    quot;
   } lane_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic              neg_x;
      logic              neg_y;
      logic              zero_len;
   } side_type;
endpackage
`default_nettype wire

// File: src/hn_if.sv
// ----------------------------------------------------------------------------
// hn_if
// Request, response and register write channels of the normal kernel.
// ----------------------------------------------------------------------------
`default_nettype none
interface hn_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [hn_pkg::FIELD_INDEX_W-1:0]       column;
   logic [hn_pkg::FIELD_INDEX_W-1:0]       row;
   logic signed [hn_pkg::HEIGHT_W-1:0]     height_sw;
   logic signed [hn_pkg::HEIGHT_W-1:0]     height_nw;
   logic signed [hn_pkg::HEIGHT_W-1:0]     height_se;
   logic signed [hn_pkg::HEIGHT_W-1:0]     height_ne;
   modport source (output valid, column, row, height_sw, height_nw, height_se, height_ne,
                   input ready);
   modport sink (input valid, column, row, height_sw, height_nw, height_se, height_ne,
                 output ready);
endinterface

interface hn_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [hn_pkg::ADDR_W-1:0]         normal_address;
   logic signed [hn_pkg::NORM_W-1:0]  normal_x;
   logic signed [hn_pkg::NORM_W-1:0]  normal_y;
   logic [hn_pkg::NORMZ_W-1:0]        normal_z;
   modport source (output valid, normal_address, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, normal_address, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface hn_csr_if;
   logic                             valid;
   logic                             ready;
   logic [hn_pkg::CSR_IDX_W-1:0]     index;
   logic [hn_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/heightfield_normal.sv
// ----------------------------------------------------------------------------
// heightfield_normal
// Unit surface normal of a height grid point from its four diagonal heights.
// ----------------------------------------------------------------------------
// A request carries column, row and the heights at the four diagonal
// neighbors; the response carries the store address row*row_pitch+column and
// the normal in Q1.15. Registers grid_spacing (index 0) and row_pitch
// (index 1) are written through the csr channel, which is always ready.
// One request is taken per cycle unless the receiver stalls. There are 20
// register stages: three front stages (differences and address, squares,
// length), sixteen stages of the bit-serial rounded ratio search, one per
// quotient bit and shared by the three components in parallel lanes, and
// the output register. When the receiver stalls the whole pipeline holds,
// and req ready drops only while a response is waiting and rsp ready is low.
// Reset clears all valid bits and loads grid_spacing = 256, row_pitch = 257.
// ----------------------------------------------------------------------------
`default_nettype none
module heightfield_normal #(
   parameter int INDEX_BITS = hn_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   hn_req_if.sink      req_ch,
   hn_rsp_if.source    rsp_ch,
   hn_csr_if.sink      csr_ch
);
   import hn_pkg::*;

   localparam int IW = (INDEX_BITS < FIELD_INDEX_W) ? INDEX_BITS : FIELD_INDEX_W;

   logic [SPACING_W-1:0] spacing_ff;
   logic [PITCH_W-1:0]   pitch_ff;
   logic                 adv;

   // register writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
         pitch_ff <= PITCH_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            REG_GRID_SPACING: spacing_ff <= csr_ch.data;
            REG_ROW_PITCH:    pitch_ff <= csr_ch.data[PITCH_W-1:0];
            default:          ;
         endcase
      end
   end

   // stage 1: differences and address
   logic                          vld1_ff;
   logic signed [DIFF_W-1:0]      a1_ff, b1_ff, a1_in, b1_in;
   logic [C_W-1:0]                c1_ff, c1_in;
   logic [ADDR_W-1:0]             addr1_ff, addr1_in;
   logic signed [DIFF_W-2:0]      d1, d2;
   logic [FIELD_INDEX_W-1:0]      col_m, row_m;
   logic [FIELD_INDEX_W+PITCH_W-1:0] prod;

   always_comb begin
      col_m = FIELD_INDEX_W'(req_ch.column[IW-1:0]);
      row_m = FIELD_INDEX_W'(req_ch.row[IW-1:0]);
      d1 = (DIFF_W-1)'(req_ch.height_ne) - (DIFF_W-1)'(req_ch.height_sw);
      d2 = (DIFF_W-1)'(req_ch.height_nw) - (DIFF_W-1)'(req_ch.height_se);
      a1_in = DIFF_W'(d2) - DIFF_W'(d1);
      b1_in = -(DIFF_W'(d1) + DIFF_W'(d2));
      c1_in = {spacing_ff, 3'b000};
      prod = row_m * pitch_ff;
      addr1_in = ADDR_W'(prod + (FIELD_INDEX_W+PITCH_W)'(col_m));
   end

   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= a1_in;
         b1_ff <= b1_in;
         c1_ff <= c1_in;
         addr1_ff <= addr1_in;
      end
   end

   // stage 2: magnitudes and squares
   logic              vld2_ff;
   logic [MAG_W-1:0]  ua, ub;
   logic [SQ_W-1:0]   sqa2_ff, sqb2_ff, sqc2_ff;
   logic              nx2_ff, ny2_ff;
   logic [ADDR_W-1:0] addr2_ff;

   always_comb begin
      ua = MAG_W'(a1_ff[DIFF_W-1] ? -a1_ff : a1_ff);
      ub = MAG_W'(b1_ff[DIFF_W-1] ? -b1_ff : b1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqa2_ff <= ua * ua;
         sqb2_ff <= ub * ub;
         sqc2_ff <= SQ_W'(c1_ff * c1_ff);
         nx2_ff <= a1_ff[DIFF_W-1];
         ny2_ff <= b1_ff[DIFF_W-1];
         addr2_ff <= addr1_ff;
      end
   end

   // stage 3: squared length and search start values
   logic              vld3_ff;
   logic [LEN_W-1:0]  len3_ff, len3_in;
   lane_type          lane3_ff [NUM_LANES];
   lane_type          lane3_in [NUM_LANES];
   side_type          side3_ff, side3_in;
   logic [SQ_W-1:0]   sq_sel [NUM_LANES];

   always_comb begin
      len3_in = LEN_W'(sqa2_ff) + LEN_W'(sqb2_ff) + LEN_W'(sqc2_ff);
      sq_sel[0] = sqa2_ff;
      sq_sel[1] = sqb2_ff;
      sq_sel[2] = sqc2_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane3_in[i].residual = RES_W'({sq_sel[i], 32'd0}) - RES_W'(len3_in);
         lane3_in[i].partial = PROD_W'(0) - PROD_W'(len3_in);
         lane3_in[i].quot = '0;
      end
      side3_in.address = addr2_ff;
      side3_in.neg_x = nx2_ff;
      side3_in.neg_y = ny2_ff;
      side3_in.zero_len = (len3_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len3_ff <= len3_in;
         lane3_ff <= lane3_in;
         side3_ff <= side3_in;
      end
   end

   // ratio search stages
   logic [STEPS-1:0]  vld_ff;
   logic [LEN_W-1:0]  len_ff [STEPS-1];
   side_type          side_ff [STEPS];
   lane_type          lane_q [STEPS][NUM_LANES];

   genvar s, l;
   generate
      for (s = 0; s < STEPS; s++) begin : g_step
         for (l = 0; l < NUM_LANES; l++) begin : g_lane
            hn_root_step #(.BIT(STEPS - 1 - s)) u_step (
               .clock    (clock),
               .enable   (adv),
               .len2     ((s == 0) ? len3_ff : len_ff[(s == 0) ? 0 : s - 1]),
               .lane_in  ((s == 0) ? lane3_ff[l] : lane_q[(s == 0) ? 0 : s - 1][l]),
               .lane_out (lane_q[s][l])
            );
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STEPS-2:0], vld3_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         len_ff[0] <= len3_ff;
         side_ff[0] <= side3_ff;
         for (int i = 1; i < STEPS; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         for (int i = 1; i < STEPS - 1; i++) begin
            len_ff[i] <= len_ff[i-1];
         end
      end
   end

   // output stage: sign, saturation, flat case
   logic                 out_vld_ff;
   logic [ADDR_W-1:0]    out_addr_ff;
   logic [NORM_W-1:0]    out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic [NORMZ_W-1:0]   out_z_ff, out_z_in;
   logic [Q_W-1:0]       qx, qy, qz;
   side_type             side_l;

   always_comb begin
      side_l = side_ff[STEPS-1];
      qx = lane_q[STEPS-1][0].quot;
      qy = lane_q[STEPS-1][1].quot;
      qz = lane_q[STEPS-1][2].quot;
      if (side_l.zero_len) begin
         out_x_in = '0;
         out_y_in = '0;
         out_z_in = NORMZ_W'(NORMAL_MAX);
      end else begin
         out_x_in = side_l.neg_x ? NORM_W'(0 - qx) : ((qx > NORMAL_MAX) ? NORMAL_MAX : qx);
         out_y_in = side_l.neg_y ? NORM_W'(0 - qy) : ((qy > NORMAL_MAX) ? NORMAL_MAX : qy);
         out_z_in = NORMZ_W'((qz > NORMAL_MAX) ? NORMAL_MAX : qz);
      end
   end

   assign adv = !out_vld_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_addr_ff <= side_l.address;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.normal_address = out_addr_ff;
   assign rsp_ch.normal_x = out_x_ff;
   assign rsp_ch.normal_y = out_y_ff;
   assign rsp_ch.normal_z = out_z_ff;

   logic [STEPS+3:0] vld_all;
   assign vld_all = {out_vld_ff, vld_ff, vld3_ff, vld2_ff, vld1_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_all))
      else $error("pipeline valid bits moved during a stall");
   a_req_enter: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld1_ff)
      else $error("accepted request missing from first stage");
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[STEPS-1]) |=> out_vld_ff)
      else $error("last search stage not moved to output");
endmodule
`default_nettype wire

// File: src/hn_root_step.sv
// ----------------------------------------------------------------------------
// hn_root_step
// One restoring step of the rounded ratio search for one bit of one lane.
// ----------------------------------------------------------------------------
`default_nettype none
module hn_root_step #(
   parameter int BIT = 15
) (
   input  wire logic                         clock,
   input  wire logic                         enable,
   input  wire logic [hn_pkg::LEN_W-1:0]     len2,
   input  wire hn_pkg::lane_type             lane_in,
   output hn_pkg::lane_type                  lane_out
);
   import hn_pkg::*;

   lane_type         lane_ff, lane_in_next;
   logic [RES_W-1:0] p_ext, l_ext, term, trial;
   logic             cand_ok, take;

   always_comb begin
      cand_ok = (BIT == Q_W - 1) || !lane_in.quot[Q_W-1];
      p_ext = {{(RES_W-PROD_W){lane_in.partial[PROD_W-1]}}, lane_in.partial};
      l_ext = {{(RES_W-LEN_W){1'b0}}, len2};
      term = (p_ext + (l_ext << BIT)) << (BIT + 2);
      trial = lane_in.residual - term;
      take = cand_ok && !trial[RES_W-1];
      lane_in_next = lane_in;
      if (take) begin
         lane_in_next.residual = trial;
         lane_in_next.partial = lane_in.partial
                              + ({{(PROD_W-LEN_W){1'b0}}, len2} << (BIT + 1));
         lane_in_next.quot[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in_next;
      end
   end

   assign lane_out = lane_ff;
endmodule
`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heightfield normal kernel.
// ----------------------------------------------------------------------------
// A table of directed requests runs first: flat patches at the index and
// height extremes carry typed-in responses, and the sloped rows are checked
// against a bit-exact model of the rounded unit normal. Random phases follow.
// Each phase rewrites grid_spacing and row_pitch, including zero and full
// scale. Random idle cycles are drawn on both sides. A long response stall
// backs up the pipeline, and the bench drains the kernel before every
// register write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import hn_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 30;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 140;

   typedef struct {
      logic [FIELD_INDEX_W-1:0] column;
      logic [FIELD_INDEX_W-1:0] row;
      logic [HEIGHT_W-1:0]      sw;
      logic [HEIGHT_W-1:0]      nw;
      logic [HEIGHT_W-1:0]      se;
      logic [HEIGHT_W-1:0]      ne;
   } point_type;

   typedef struct {
      logic [ADDR_W-1:0]  address;
      logic [NORM_W-1:0]  nx;
      logic [NORM_W-1:0]  ny;
      logic [NORMZ_W-1:0] nz;
   } normal_type;

   typedef struct {
      point_type  pt;
      bit         typed;
      normal_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset;

   hn_req_if req_ch ();
   hn_rsp_if rsp_ch ();
   hn_csr_if csr_ch ();

   heightfield_normal i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [SPACING_W-1:0] spacing_q;
   logic [PITCH_W-1:0]   pitch_q;
   normal_type           normal_q[$];
   row_type              typed_q[$];
   int                   fail_count = 0;
   int                   idle_cycles = 0;
   bit                   tx_nogap = 0;
   bit                   rx_nogap = 0;
   bit                   rx_hold = 0;

   function automatic logic [16:0] rounded_ratio(logic [25:0] mag, logic [55:0] len2);
      logic [16:0]  q;
      logic [16:0]  cand;
      logic [33:0]  k2;
      logic [127:0] lhs;
      logic [127:0] rhs;
      q = '0;
      rhs = 128'(mag) * 128'(mag);
      rhs = rhs << 32;
      for (int b = 15; b >= 0; b--) begin
         cand = q | (17'd1 << b);
         k2 = 34'(2 * cand - 1) * 34'(2 * cand - 1);
         lhs = 128'(k2) * 128'(len2);
         if (cand <= 17'd32768 && lhs <= rhs) q = cand;
      end
      return q;
   endfunction

   function automatic logic [NORM_W-1:0] signed_part(logic signed [26:0] v,
                                                     logic [55:0] len2);
      logic [25:0] mag;
      logic [16:0] q;
      mag = v < 0 ? 26'(-v) : 26'(v);
      q = rounded_ratio(mag, len2);
      if (v < 0) return 16'(-q);
      return q > 17'd32767 ? NORMAL_MAX : 16'(q);
   endfunction

   function automatic normal_type predict_normal(point_type p);
      logic signed [26:0] d1;
      logic signed [26:0] d2;
      logic signed [26:0] a;
      logic signed [26:0] b;
      logic [25:0]        ua;
      logic [25:0]        ub;
      logic [19:0]        c;
      logic [55:0]        len2;
      logic [16:0]        z;
      normal_type         n;
      d1 = 27'($signed(p.ne)) - 27'($signed(p.sw));
      d2 = 27'($signed(p.nw)) - 27'($signed(p.se));
      a = d2 - d1;
      b = -(d1 + d2);
      c = 20'(spacing_q) * 20'd8;
      ua = a < 0 ? 26'(-a) : 26'(a);
      ub = b < 0 ? 26'(-b) : 26'(b);
      len2 = 56'(ua) * 56'(ua) + 56'(ub) * 56'(ub) + 56'(c) * 56'(c);
      n.address = 24'(32'(p.row) * 32'(pitch_q) + 32'(p.column));
      if (len2 == 0) begin
         n.nx = '0;
         n.ny = '0;
         n.nz = 15'd32767;
      end else begin
         n.nx = signed_part(a, len2);
         n.ny = signed_part(b, len2);
         z = rounded_ratio(26'(c), len2);
         n.nz = z > 17'd32767 ? 15'd32767 : 15'(z);
      end
      return n;
   endfunction

   always @(posedge clock) begin
      row_type    r;
      normal_type got;
      normal_type want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == REG_GRID_SPACING) spacing_q <= csr_ch.data;
            else if (csr_ch.index == REG_ROW_PITCH) pitch_q <= PITCH_W'(csr_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            r = typed_q.pop_front();
            normal_q.push_back(r.typed ? r.want : predict_normal(r.pt));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.address = rsp_ch.normal_address;
            got.nx = rsp_ch.normal_x;
            got.ny = rsp_ch.normal_y;
            got.nz = rsp_ch.normal_z;
            if (normal_q.size() == 0) begin
               $display("%0t: unexpected response addr=%0d x=%0d y=%0d z=%0d", $time,
                        got.address, $signed(got.nx), $signed(got.ny), got.nz);
               fail_count++;
            end else begin
               want = normal_q.pop_front();
               if (got.address !== want.address) begin
                  $display("%0t: address expected %0d actual %0d", $time, want.address,
                           got.address);
                  fail_count++;
               end
               if (got.nx !== want.nx) begin
                  $display("%0t: normal_x expected %0d actual %0d", $time,
                           $signed(want.nx), $signed(got.nx));
                  fail_count++;
               end
               if (got.ny !== want.ny) begin
                  $display("%0t: normal_y expected %0d actual %0d", $time,
                           $signed(want.ny), $signed(got.ny));
                  fail_count++;
               end
               if (got.nz !== want.nz) begin
                  $display("%0t: normal_z expected %0d actual %0d", $time, want.nz,
                           got.nz);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rx_hold = 0;
         end
         n = rx_nogap ? 0 : $urandom_range(0, 19);
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         if ($urandom_range(0, 99) == 0) rx_nogap = !rx_nogap;
      end
   end

   task automatic send_point(row_type r);
      int gap;
      gap = tx_nogap ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_q.push_back(r);
      req_ch.valid <= 1'b1;
      req_ch.column <= r.pt.column;
      req_ch.row <= r.pt.row;
      req_ch.height_sw <= r.pt.sw;
      req_ch.height_nw <= r.pt.nw;
      req_ch.height_se <= r.pt.se;
      req_ch.height_ne <= r.pt.ne;
      do @(posedge clock); while (!req_ch.ready);
      if ($urandom_range(0, 29) == 0) tx_nogap = !tx_nogap;
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      while (normal_q.size() != 0 || typed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves valid high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   function automatic logic [HEIGHT_W-1:0] random_height(logic [HEIGHT_W-1:0] base);
      int unsigned mode;
      mode = $urandom_range(0, 3);
      if (mode == 0) return base;
      if (mode == 1) return base + HEIGHT_W'($urandom_range(0, 2047)) - HEIGHT_W'(1024);
      return HEIGHT_W'($urandom);
   endfunction

   function automatic row_type plain(logic [11:0] c, logic [11:0] r, logic [23:0] sw,
                                     logic [23:0] nw, logic [23:0] se, logic [23:0] ne);
      row_type t;
      t.pt = '{c, r, sw, nw, se, ne};
      t.typed = 0;
      t.want = '{default: '0};
      return t;
   endfunction

   function automatic row_type flat(logic [11:0] c, logic [11:0] r, logic [23:0] h,
                                    logic [23:0] addr);
      row_type t;
      t = plain(c, r, h, h, h, h);
      t.typed = 1;
      t.want = '{addr, 16'd0, 16'd0, 15'd32767};
      return t;
   endfunction

   localparam logic [23:0] HMAX = 24'h7FFFFF;
   localparam logic [23:0] HMIN = 24'h800000;

   initial begin
      row_type stim_table[$];
      row_type t;
      logic [23:0] base;
      int      spacing_set[7] = '{1, 65535, 0, 0, 256, 3, 40000};
      int      pitch_set[7] = '{1, 4096, 8191, 0, 257, 4095, 1000};

      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.column <= '0;
      req_ch.row <= '0;
      req_ch.height_sw <= '0;
      req_ch.height_nw <= '0;
      req_ch.height_se <= '0;
      req_ch.height_ne <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_GRID_SPACING;
      csr_ch.data <= '0;
      spacing_q = SPACING_RESET;
      pitch_q = PITCH_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      stim_table.push_back(flat(12'd0, 12'd0, 24'd0, 24'd0));
      stim_table.push_back(flat(12'd4095, 12'd4095, HMAX, 24'd1056510));
      stim_table.push_back(flat(12'd4095, 12'd0, HMIN, 24'd4095));
      stim_table.push_back(flat(12'd0, 12'd4095, 24'd1, 24'd1052415));
      stim_table.push_back(plain(12'd1, 12'd2, HMIN, 24'd0, 24'd0, HMAX));
      stim_table.push_back(plain(12'd3, 12'd4, HMAX, 24'd0, 24'd0, HMIN));
      stim_table.push_back(plain(12'd5, 12'd6, 24'd0, HMAX, HMIN, 24'd0));
      stim_table.push_back(plain(12'd7, 12'd8, 24'd0, HMIN, HMAX, 24'd0));
      stim_table.push_back(plain(12'd9, 12'd10, HMIN, HMAX, HMIN, HMAX));
      stim_table.push_back(plain(12'd11, 12'd12, HMAX, HMIN, HMAX, HMIN));
      stim_table.push_back(plain(12'd13, 12'd14, HMIN, HMIN, HMAX, HMAX));
      stim_table.push_back(plain(12'd15, 12'd16, HMAX, HMAX, HMIN, HMIN));
      stim_table.push_back(plain(12'd17, 12'd18, 24'd0, 24'd0, 24'd0, 24'd2048));
      stim_table.push_back(plain(12'd19, 12'd20, 24'd0, 24'd1, 24'd0, 24'd0));
      stim_table.push_back(plain(12'd21, 12'd22, 24'hFFFFFF, 24'd7, 24'd3, 24'd100));
      foreach (stim_table[i]) send_point(stim_table[i]);

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         write_reg(REG_GRID_SPACING, CSR_DATA_W'(spacing_set[ph]));
         write_reg(REG_ROW_PITCH, CSR_DATA_W'(pitch_set[ph]));
         csr_ch.valid <= 1'b0;
         for (int i = 0; i < PHASE_ITEMS * 6 / 7; i++) begin
            if (ph == 4 && i == 20) rx_hold = 1;
            base = HEIGHT_W'($urandom);
            t = plain(FIELD_INDEX_W'($urandom), FIELD_INDEX_W'($urandom),
                      random_height(base), random_height(base),
                      random_height(base), random_height(base));
            send_point(t);
         end
      end
      req_ch.valid <= 1'b0;
      while (normal_q.size() != 0 || typed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && normal_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
src/hn_pkg.sv
src/hn_if.sv
src/hn_root_step.sv
src/heightfield_normal.sv
test/tb.sv
